// ----- rtl/core/id3_pkg.sv -----
package id3_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_FRAME_ID    = 2'd0;
  localparam logic [1:0] REG_CMP_LENGTH  = 2'd1;
  localparam logic [1:0] REG_STRING_MODE = 2'd2;

  localparam logic [31:0] FRAME_ID_RESET    = 32'd1414091826;
  localparam logic [2:0]  CMP_LENGTH_RESET  = 3'd4;
  localparam logic        STRING_MODE_RESET = 1'b0;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  // Tag format constants
  localparam logic [23:0] TAG_SIGNATURE   = 24'h494433;  // "ID3"
  localparam logic [15:0] VERSION_FOUR    = 16'h0400;
  localparam logic [15:0] VERSION_THREE   = 16'h0300;
  localparam int          FLAG_UNSYNC     = 7;
  localparam int          FLAG_EXT_HEADER = 6;
  localparam logic [32:0] FRAME_HDR_BYTES = 33'd10;     // id + size + flags

  // Status codes
  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_BADSIG   = 3'd1;
  localparam logic [2:0] ST_BADVER   = 3'd2;
  localparam logic [2:0] ST_BADFLAGS = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_BADENC   = 3'd5;
  localparam logic [2:0] ST_TRUNC    = 3'd6;

  // Text encodings that are refused in string mode
  localparam logic [7:0] ENC_UTF16     = 8'd1;
  localparam logic [7:0] ENC_UTF16_BE  = 8'd2;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [2:0]  cmp_length;
    logic        string_mode;
  } cfg_t;

  typedef struct packed {
    logic        have;
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic        last;
    logic [31:0] size;
  } result_t;

endpackage

// ----- rtl/core/id3_cfg.sv -----
module id3_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [id3_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [id3_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [id3_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output id3_pkg::cfg_t                   cfg
);
  import id3_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register writes; addresses past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_id    <= FRAME_ID_RESET;
      cfg.cmp_length  <= CMP_LENGTH_RESET;
      cfg.string_mode <= STRING_MODE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_ID:    cfg.frame_id    <= pwdata;
        REG_CMP_LENGTH:  cfg.cmp_length  <= pwdata[2:0];
        REG_STRING_MODE: cfg.string_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_ID:    prdata = cfg.frame_id;
      REG_CMP_LENGTH:  prdata = {29'd0, cfg.cmp_length};
      REG_STRING_MODE: prdata = {31'd0, cfg.string_mode};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/id3_parser.sv -----
module id3_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             in_eof,
  input  id3_pkg::cfg_t    cfg,
  output id3_pkg::result_t res
);
  import id3_pkg::*;

  typedef enum logic [10:0] {
    PH_SIG   = 11'b000_0000_0001,
    PH_VER   = 11'b000_0000_0010,
    PH_FLAGS = 11'b000_0000_0100,
    PH_TSIZE = 11'b000_0000_1000,
    PH_FID   = 11'b000_0001_0000,
    PH_FSIZE = 11'b000_0010_0000,
    PH_FFLAG = 11'b000_0100_0000,
    PH_SKIP  = 11'b000_1000_0000,
    PH_ENC   = 11'b001_0000_0000,
    PH_EMIT  = 11'b010_0000_0000,
    PH_DONE  = 11'b100_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  count, count_next, count_inc;
  logic        v4, v4_next;
  logic [31:0] seen, seen_next;
  logic [31:0] acc, acc_next;
  logic [27:0] tag, tag_next, tag_after_skip;
  logic [31:0] left, left_next, left_dec;
  logic [32:0] cost, cost_next;   // header bytes plus frame size, for the skip

  logic        fin, skipped, id_match;
  logic [2:0]  fin_status;
  logic [31:0] fin_size;
  logic [31:0] id_mask;

  // Leading characters that must match; zero compares nothing, above four acts as four
  always_comb begin
    case (cfg.cmp_length)
      3'd0:    id_mask = 32'h0000_0000;
      3'd1:    id_mask = 32'hFF00_0000;
      3'd2:    id_mask = 32'hFFFF_0000;
      3'd3:    id_mask = 32'hFFFF_FF00;
      default: id_mask = 32'hFFFF_FFFF;
    endcase
  end

  assign id_match  = (seen & id_mask) == (cfg.frame_id & id_mask);
  assign count_inc = count + 4'd1;
  assign left_dec  = left - 32'd1;

  // Tag budget after a skipped frame, floored at zero
  assign tag_after_skip = ({5'd0, tag} > cost) ? (tag - cost[27:0]) : 28'd0;

  always_comb begin
    phase_next = phase;
    count_next = count;
    v4_next    = v4;
    seen_next  = seen;
    acc_next   = acc;
    tag_next   = tag;
    left_next  = left;
    cost_next  = cost;
    fin        = 1'b0;
    fin_status = ST_FOUND;
    fin_size   = '0;
    skipped    = 1'b0;
    res        = '0;

    unique case (phase)
      PH_SIG: begin
        seen_next  = {seen[23:0], in_byte};
        count_next = count_inc;
        if (count_inc >= 4'd3) begin
          if (seen_next[23:0] != TAG_SIGNATURE) begin
            fin = 1'b1; fin_status = ST_BADSIG;
          end else begin
            phase_next = PH_VER;
            count_next = '0;
            acc_next   = '0;
          end
        end
      end
      PH_VER: begin
        acc_next   = {acc[23:0], in_byte};
        count_next = count_inc;
        if (count_inc >= 4'd2) begin
          if (acc_next[15:0] == VERSION_FOUR) begin
            v4_next = 1'b1; phase_next = PH_FLAGS;
          end else if (acc_next[15:0] == VERSION_THREE) begin
            v4_next = 1'b0; phase_next = PH_FLAGS;
          end else begin
            fin = 1'b1; fin_status = ST_BADVER;
          end
        end
      end
      PH_FLAGS: begin
        if (in_byte[FLAG_UNSYNC] || in_byte[FLAG_EXT_HEADER]) begin
          fin = 1'b1; fin_status = ST_BADFLAGS;
        end else begin
          phase_next = PH_TSIZE;
          count_next = '0;
          acc_next   = '0;
        end
      end
      PH_TSIZE: begin
        acc_next   = {acc[24:0], in_byte[6:0]};
        count_next = count_inc;
        if (count_inc >= 4'd4) begin
          tag_next = acc_next[27:0];
          if (acc_next[27:0] == 28'd0) begin
            fin = 1'b1; fin_status = ST_NOTFOUND;
          end else begin
            phase_next = PH_FID;
            count_next = '0;
          end
        end
      end
      PH_FID: begin
        if (count == 4'd0 && in_byte == 8'd0) begin
          fin = 1'b1; fin_status = ST_NOTFOUND;
        end else begin
          seen_next  = {seen[23:0], in_byte};
          count_next = count_inc;
          if (count_inc >= 4'd4) begin
            phase_next = PH_FSIZE;
            count_next = '0;
            acc_next   = '0;
          end
        end
      end
      PH_FSIZE: begin
        // syncsafe in 2.4, plain big-endian in 2.3
        if (v4) acc_next = {acc[24:0], in_byte[6:0]};
        else    acc_next = {acc[23:0], in_byte};
        count_next = count_inc;
        if (count_inc >= 4'd4) begin
          left_next  = acc_next;
          phase_next = PH_FFLAG;
          count_next = '0;
        end
      end
      PH_FFLAG: begin
        count_next = count_inc;
        if (count_inc < 4'd2) begin
          cost_next = {1'b0, acc} + FRAME_HDR_BYTES;
        end else if (id_match) begin
          if (left == 32'd0) begin
            fin = 1'b1; fin_status = ST_FOUND; fin_size = acc;
          end else begin
            phase_next = cfg.string_mode ? PH_ENC : PH_EMIT;
          end
        end else if (left == 32'd0) begin
          skipped = 1'b1;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        left_next = left_dec;
        if (left_dec == 32'd0) skipped = 1'b1;
      end
      PH_ENC: begin
        left_next = left_dec;
        if (in_byte == ENC_UTF16 || in_byte == ENC_UTF16_BE) begin
          fin = 1'b1; fin_status = ST_BADENC;
        end else if (left_dec == 32'd0) begin
          fin = 1'b1; fin_status = ST_FOUND; fin_size = acc;
        end else begin
          phase_next = PH_EMIT;
        end
      end
      PH_EMIT: begin
        left_next  = left_dec;
        res.have   = 1'b1;
        res.kind   = 1'b0;
        res.data   = in_byte;
        res.status = ST_FOUND;
        res.size   = acc;
        res.last   = (left_dec == 32'd0);
        if (left_dec == 32'd0) phase_next = PH_DONE;
      end
      PH_DONE: ;
      default: ;
    endcase

    // Frame skipped: charge it against the tag budget
    if (skipped) begin
      tag_next = tag_after_skip;
      if (tag_after_skip == 28'd0) begin
        fin = 1'b1; fin_status = ST_NOTFOUND;
      end else begin
        phase_next = PH_FID;
        count_next = '0;
      end
    end

    // Final status-only result
    if (fin) begin
      res.have   = 1'b1;
      res.kind   = 1'b1;
      res.data   = '0;
      res.status = fin_status;
      res.last   = 1'b1;
      res.size   = fin_size;
      phase_next = PH_DONE;
    end

    // End of file: truncate an unfinished search and start over
    if (in_eof) begin
      if (res.have && !res.last) begin
        res.last   = 1'b1;
        res.status = ST_TRUNC;
        res.size   = '0;
      end else if (!res.have && phase_next != PH_DONE) begin
        res.have   = 1'b1;
        res.kind   = 1'b1;
        res.data   = '0;
        res.status = ST_TRUNC;
        res.last   = 1'b1;
        res.size   = '0;
      end
      phase_next = PH_SIG;
      count_next = '0;
      v4_next    = 1'b0;
      seen_next  = '0;
      acc_next   = '0;
      tag_next   = '0;
      left_next  = '0;
      cost_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SIG;
      count <= '0;
      v4    <= 1'b0;
      seen  <= '0;
      acc   <= '0;
      tag   <= '0;
      left  <= '0;
      cost  <= '0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
      v4    <= v4_next;
      seen  <= seen_next;
      acc   <= acc_next;
      tag   <= tag_next;
      left  <= left_next;
      cost  <= cost_next;
    end
  end

endmodule

// ----- rtl/core/id3v2_frame_extractor.sv -----
// ID3v2 frame extractor.
// Input stream: one file byte per transfer. s_axis_tdata[7:0] is the byte,
// s_axis_tlast marks the final byte of a file; the next byte starts a new file.
// Output stream: zero or one result per input byte. Payload bytes of the first
// matching frame come out with tuser 0; a status-only result has tuser 1.
// m_axis_tlast marks the final result of a file.
// Configuration: APB registers at 0x0 (wanted frame ID), 0x4 (compare length),
// 0x8 (string mode); write them only while the stream is idle.
// A result travels from its byte through the input register and the result
// register. Throughput is one byte per cycle while the receiver keeps up; the
// parser step between those two registers is combinational.
// Reset (synchronous, active high) empties both registers, returns the parser
// to the signature phase and loads the register defaults.
// When the receiver stalls, the held result stays put; one more byte can sit
// in the input register, and then s_axis_tready drops until the result moves.
module id3v2_frame_extractor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [id3_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic                             s_axis_tlast,   // end_of_file
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] payload_byte, [10:8] status_code, [42:11] frame_size, [47:43] zero
  output logic [id3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,   // last_result
  output logic                             m_axis_tuser,   // result_kind
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [id3_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [id3_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [id3_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import id3_pkg::*;

  cfg_t       cfg;
  result_t    step_res;
  result_t    out_res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eof;
  logic       advance;

  id3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Parser steps when a byte is held and the result register can take its result
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  id3_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .in_eof  (in_eof),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata[7:0];
      in_eof  <= s_axis_tlast;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= advance && step_res.have;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {5'd0, out_res.size, out_res.status, out_res.data};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.kind;

endmodule

// ----- rtl/core/id3_checker.sv -----
module id3_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [id3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tuser
);
  import id3_pkg::*;

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Status-only results close the file and carry no byte
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("status-only result malformed");

  // Frame size is reported only with the found status
  a_size_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10:8] != ST_FOUND |-> m_axis_tdata[42:11] == 32'd0)
    else $error("frame size on a failing status");

  // Results before the last are found payload bytes
  a_mid_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser && m_axis_tdata[10:8] == ST_FOUND)
    else $error("non-final result is not a payload byte");

endmodule

bind id3v2_frame_extractor id3_checker u_id3_checker (.*);
